// ----- src/cid_pkg.sv -----
package cid_pkg;

    localparam int BYTE_W    = 8;
    localparam int MAG_W     = 31;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int LEN_W     = 3;
    localparam int COUNT_W   = 3;
    localparam int MAX_BYTES = 5;

    // Payload bits of the fifth byte that still fit in the 31-bit magnitude.
    localparam logic [6:0] LAST_PAYLOAD_MAX = 7'h0f;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_OVERFLOW = 2'd1,
        STATUS_TOO_LONG = 2'd2
    } cid_status_t;

endpackage

// ----- src/cid_byte_if.sv -----
interface cid_byte_if;

    logic                       valid;
    logic                       ready;
    logic [cid_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);

endinterface

// ----- src/cid_result_if.sv -----
interface cid_result_if;

    logic                                valid;
    logic                                ready;
    logic signed [cid_pkg::VALUE_W-1:0]  value;
    logic [cid_pkg::STATUS_W-1:0]        status;
    logic [cid_pkg::LEN_W-1:0]           length;

    modport source (output valid, output value, output status, output length, input ready);
    modport sink   (input valid, input value, input status, input length, output ready);

endinterface

// ----- src/compact_index_decoder.sv -----
// Channel     Direction  Payload                      Transfer
// byte_in     sink       in_byte[7:0]                 valid && ready
// result_out  source     value[31:0], status, length  valid && ready
//
// Each byte is held in the input register and is decoded on its way
// into the result register, so one byte is taken every cycle unless a held result stalls it.
// A completed value or an error is loaded into the result register when its last byte leaves
// the input register; bytes that only continue a value produce no transfer.
// Reset clears the input and result valid flags and the decode state.
// A held result stalls only a byte that would produce another result.
module compact_index_decoder (
    input  logic          clk,
    input  logic          rst_n,
    cid_byte_if.sink      byte_in,
    cid_result_if.source  result_out
);
    import cid_pkg::*;

    logic                      s1_valid_reg;
    logic [BYTE_W-1:0]         s1_byte_reg;

    logic [MAG_W-1:0]          acc_reg;
    logic [MAG_W-1:0]          acc_next;
    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;
    logic                      sign_reg;
    logic                      sign_next;

    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic [STATUS_W-1:0]       out_status_reg;
    logic [LEN_W-1:0]          out_length_reg;

    logic                      emit;
    logic signed [VALUE_W-1:0] res_value;
    cid_status_t               res_status;
    logic [LEN_W-1:0]          res_length;

    logic                      advance;
    logic                      first_byte;
    logic                      last_byte;
    logic [6:0]                payload;
    logic                      more;
    logic [MAG_W-1:0]          shifted;
    logic [MAG_W-1:0]          acc_or;
    logic [MAG_W-1:0]          mag;
    logic                      mag_neg;

    assign payload    = s1_byte_reg[6:0];
    assign more       = s1_byte_reg[7];
    assign first_byte = (count_reg == '0) || (count_reg >= COUNT_W'(MAX_BYTES));
    assign last_byte  = (count_reg == COUNT_W'(MAX_BYTES - 1));

    // Position of the new payload bits depends only on how many bytes came before.
    always_comb
    begin
        unique case (count_reg)
            3'd1:    shifted = MAG_W'(payload) << 6;
            3'd2:    shifted = MAG_W'(payload) << 13;
            3'd3:    shifted = MAG_W'(payload) << 20;
            3'd4:    shifted = MAG_W'(payload) << 27;
            default: shifted = '0;
        endcase
    end

    assign acc_or = acc_reg | shifted;

    always_comb
    begin
        emit       = 1'b0;
        res_status = STATUS_OK;
        res_length = LEN_W'(1);
        mag        = '0;
        mag_neg    = 1'b0;
        acc_next   = acc_reg;
        count_next = count_reg;
        sign_next  = sign_reg;

        if (first_byte)
        begin
            sign_next = s1_byte_reg[7];
            acc_next  = MAG_W'(s1_byte_reg[5:0]);
            if (!s1_byte_reg[6])
            begin
                emit       = 1'b1;
                mag        = MAG_W'(s1_byte_reg[5:0]);
                mag_neg    = s1_byte_reg[7];
                count_next = '0;
            end
            else
            begin
                count_next = COUNT_W'(1);
            end
        end
        else if (last_byte && (payload > LAST_PAYLOAD_MAX))
        begin
            emit       = 1'b1;
            res_status = STATUS_OVERFLOW;
            res_length = LEN_W'(MAX_BYTES);
            count_next = '0;
        end
        else if (last_byte && more)
        begin
            emit       = 1'b1;
            res_status = STATUS_TOO_LONG;
            res_length = LEN_W'(MAX_BYTES);
            count_next = '0;
        end
        else if (!more)
        begin
            emit       = 1'b1;
            mag        = acc_or;
            mag_neg    = sign_reg;
            res_length = LEN_W'(count_reg + COUNT_W'(1));
            count_next = '0;
        end
        else
        begin
            acc_next   = acc_or;
            count_next = count_reg + COUNT_W'(1);
        end
    end

    // Negative zero falls out as zero from the two's complement negate.
    assign res_value = mag_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    assign advance       = s1_valid_reg && (!emit || !out_valid_reg || result_out.ready);
    assign byte_in.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (byte_in.ready)
        begin
            s1_valid_reg <= byte_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            s1_byte_reg <= byte_in.in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            count_reg <= '0;
            sign_reg  <= 1'b0;
        end
        else if (advance)
        begin
            acc_reg   <= acc_next;
            count_reg <= count_next;
            sign_reg  <= sign_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_value_reg  <= res_value;
            out_status_reg <= res_status;
            out_length_reg <= res_length;
        end
    end

    assign result_out.valid  = out_valid_reg;
    assign result_out.value  = out_value_reg;
    assign result_out.status = out_status_reg;
    assign result_out.length = out_length_reg;

    // The byte count never reaches the fifth position between bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_BYTES - 1))
        else $error("byte count beyond four");

    // Errors always report a full five-byte length and a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != STATUS_OK)) |->
        ((out_length_reg == LEN_W'(MAX_BYTES)) && (out_value_reg == '0)))
        else $error("error result with wrong length or value");

    // A decoded result is presented in the cycle after its last byte moves on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit) |=> (out_valid_reg && (count_reg == '0)))
        else $error("result lost or count not cleared");

    // Every result length lies between one and five bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
        ((out_length_reg != '0) && (out_length_reg <= LEN_W'(MAX_BYTES))))
        else $error("result length out of range");

endmodule
